// ===== src/pvff_pkg.sv =====
// Shared constants for the polyline virtual fixture force unit.
// Used by the top level and by its port checker. No dependencies.
`timescale 1ns / 1ps

package pvff_pkg;

    // default geometry
    localparam int DEF_PATH_DEPTH = 1024;
    localparam int DEF_COORD_BITS = 24;

    // fixed field widths
    localparam int IDX_W   = 10;   // vertex_index, nearest_index
    localparam int LEN_W   = 11;   // path_length register
    localparam int BAND_W  = 20;   // band_width register
    localparam int FMAX_W  = 19;   // force_max register
    localparam int FORCE_W = 20;   // force outputs
    localparam int CFG_IW  = 2;    // config register index
    localparam int CFG_DW  = 20;   // config write data

    // limits
    localparam int FORCE_LIMIT = 500000;
    localparam int BAND_LIMIT  = 1000000;

    // register reset values
    localparam logic [LEN_W-1:0]  LEN_RESET  = 11'd2;
    localparam logic [BAND_W-1:0] BAND_RESET = 20'd20000;
    localparam logic [FMAX_W-1:0] FMAX_RESET = 19'd500000;

    // config register indexes
    localparam logic [CFG_IW-1:0] CFG_PATH_LENGTH = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_BAND_WIDTH  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_FORCE_MAX   = 2'd2;

    // item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

// ===== src/polyline_virtual_fixture_force_unit.sv =====
// Polyline virtual fixture force unit: vertex table, nearest point search,
// projection, square root and force shaping on one shared multiplier/divider.
// Depends on pvff_pkg.
`timescale 1ns / 1ps

// A load word (mode 0) writes one vertex; busy stays low.
// A query word (mode 1) raises busy and returns one result strobed on o_valid
// for exactly one cycle; the receiver cannot stall it. During a query the
// vertex scan needs two passes of the single multiplier per vertex, then
// the four foot offsets (when both neighbour segments are projected), the
// square root and the three force divisions each run bit-serially through
// the shared restoring divider and root unit. The vertex table is not
// cleared at reset; load every slot below path_length before the first query.
module polyline_virtual_fixture_force_unit
    import pvff_pkg::*;
#(
    parameter int PATH_DEPTH = DEF_PATH_DEPTH,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command side
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_mode,
    input  logic [IDX_W-1:0]             i_vertex_index,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    // result side
    output logic                         o_valid,
    output logic signed [FORCE_W-1:0]    o_force_x,
    output logic signed [FORCE_W-1:0]    o_force_y,
    output logic signed [COORD_BITS:0]   o_error_x,
    output logic signed [COORD_BITS:0]   o_error_y,
    output logic [IDX_W-1:0]             o_nearest_index,
    // config write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IW-1:0]            i_cfg_index,
    input  logic [CFG_DW-1:0]            i_cfg_data
);

    localparam int CW   = COORD_BITS;
    localparam int DW   = CW + 1;                 // coordinate differences
    localparam int PW   = 2 * DW;                 // squares
    localparam int MW   = (DW > 20) ? DW : 20;    // multiplier operand
    localparam int QW   = MW + 1;                 // quotient bits
    localparam int NW   = 3 * DW + 1;             // dividend
    localparam int RW   = 2 * DW + 2;             // remainder / divisor
    localparam int SW   = 2 * DW + 2;             // root operand
    localparam int EW   = DW + 1;                 // root result
    localparam int BW2  = (EW > 21) ? EW : 21;    // band compare
    localparam int AW   = $clog2(PATH_DEPTH);
    localparam int IW   = $clog2(PATH_DEPTH + 1);
    localparam int CNTW = $clog2(QW + SW + 1);
    localparam logic [SW-1:0] SQ_TOP = {2'b01, {(SW-2){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_PRE, S_SCAN0, S_SCAN1, S_SCAN_END,
        S_SEG_SEL, S_GET_B, S_DEN0, S_DEN1, S_NUM0, S_NUM1, S_CHK,
        S_OFF0, S_OFF1, S_OFF2, S_OFF3, S_DIV,
        S_FD0, S_FD1, S_FD2, S_SQRT,
        S_FRC0, S_FRC1, S_FRC2, S_FRC3, S_FRC4, S_FRC5, S_FRC6
    } t_state;

    function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    // config registers
    logic [LEN_W-1:0]  r_cfg_len;
    logic [BAND_W-1:0] r_cfg_band;
    logic [FMAX_W-1:0] r_cfg_fmax;

    // control
    t_state          r_state, r_ret;
    logic            r_valid;
    logic [IW-1:0]   r_n, r_idx, r_cidx;
    logic            r_pend;
    logic [1:0]      r_seg;
    logic            r_axis;
    logic [CNTW-1:0] r_cnt;
    logic            r_fzero;

    // datapath
    logic [CW-1:0]     r_px, r_py;
    logic [BAND_W-1:0] r_band;
    logic [FMAX_W-1:0] r_fmax;
    logic [DW-1:0]     r_cx, r_cy, r_ex, r_ey, r_qx, r_qy, r_dx, r_dy, r_fx, r_fy;
    logic [PW-1:0]     r_sqx, r_nacc;
    logic [PW:0]       r_best, r_den;
    logic [PW+1:0]     r_num;
    logic [AW-1:0]     r_near;
    logic [QW-1:0]     r_dlo;
    logic [RW-1:0]     r_rem, r_dden;
    logic [SW-1:0]     r_s, r_r, r_bit;
    logic [FMAX_W-1:0] r_f;
    logic [FORCE_W-1:0] r_fox;
    logic [FORCE_W-1:0] r_out_fx, r_out_fy;
    logic [DW-1:0]     r_out_ex, r_out_ey;
    logic [IDX_W-1:0]  r_out_near;

    // memory
    logic [CW-1:0] mem_x [PATH_DEPTH];
    logic [CW-1:0] mem_y [PATH_DEPTH];
    logic [CW-1:0] r_rd_x, r_rd_y;
    logic [AW-1:0] rd_addr;

    // shared multiplier
    logic [MW-1:0]   mul_a, mul_b;
    logic            mul_neg;
    logic [2*MW-1:0] r_prod;
    logic            r_psgn;

    // combinational helpers
    logic             accept, ld_we;
    logic [IW-1:0]    n_len;
    logic [BAND_W-1:0] n_band;
    logic [FMAX_W-1:0] n_fmax;
    logic [DW-1:0]    cx_new, cy_new, bx_rel, by_rel;
    logic [PW:0]      pair_sum;
    logic             scan_upd;
    logic             seg_prev, seg_next;
    logic [PW+1:0]    prod_s, num_f;
    logic             skip_seg;
    logic [DW-1:0]    d_axis, q_axis;
    logic [NW-1:0]    div_n;
    logic [RW-1:0]    div_d;
    logic             div_load;
    logic [RW-1:0]    div_t;
    logic             div_ge;
    logic             rnd;
    logic [DW:0]      ox, ox_s, foot;
    logic [SW-1:0]    sq_rb;
    logic [EW-1:0]    e_val;
    logic [BW2-1:0]   e_w, band_w, band2_w;
    logic             f_is_zero;
    logic [BAND_W-1:0] x_val;
    logic [FMAX_W-1:0] f_now;
    logic [FORCE_W-1:0] m_clamp;

    assign accept      = i_start && !o_busy;
    assign ld_we       = accept && (i_mode == MODE_LOAD) && (int'(i_vertex_index) < PATH_DEPTH);
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_force_x   = r_out_fx;
    assign o_force_y   = r_out_fy;
    assign o_error_x   = r_out_ex;
    assign o_error_y   = r_out_ey;
    assign o_nearest_index = r_out_near;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len  <= LEN_RESET;
            r_cfg_band <= BAND_RESET;
            r_cfg_fmax <= FMAX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PATH_LENGTH: r_cfg_len  <= i_cfg_data[LEN_W-1:0];
                CFG_BAND_WIDTH:  r_cfg_band <= i_cfg_data[BAND_W-1:0];
                CFG_FORCE_MAX:   r_cfg_fmax <= i_cfg_data[FMAX_W-1:0];
                default: ;
            endcase
        end
    end

    // register saturation at query start
    always_comb begin
        if (r_cfg_len < LEN_W'(2))
            n_len = IW'(2);
        else if (int'(r_cfg_len) > PATH_DEPTH)
            n_len = IW'(PATH_DEPTH);
        else
            n_len = IW'(r_cfg_len);
        if (r_cfg_band == '0)
            n_band = BAND_W'(1);
        else if (int'(r_cfg_band) > BAND_LIMIT)
            n_band = BAND_W'(BAND_LIMIT);
        else
            n_band = r_cfg_band;
        n_fmax = (int'(r_cfg_fmax) > FORCE_LIMIT) ? FMAX_W'(FORCE_LIMIT) : r_cfg_fmax;
    end

    // vertex table
    always_ff @(posedge i_clk) begin
        if (ld_we) begin
            mem_x[AW'(i_vertex_index)] <= i_pos_x;
            mem_y[AW'(i_vertex_index)] <= i_pos_y;
        end
        r_rd_x <= mem_x[rd_addr];
        r_rd_y <= mem_y[rd_addr];
    end

    // segment choice
    assign seg_prev = (r_seg == 2'd0) && (r_near != '0);
    assign seg_next = !seg_prev && (r_seg != 2'd2) && ((IW'(r_near) + IW'(1)) < r_n);

    // read address
    always_comb begin
        rd_addr = '0;
        case (r_state)
            S_SCAN1:   rd_addr = AW'(r_idx + IW'(1));
            S_SEG_SEL: rd_addr = seg_prev ? (r_near - AW'(1)) : (r_near + AW'(1));
            default:   rd_addr = '0;
        endcase
    end

    // scan helpers
    assign cx_new   = {r_rd_x[CW-1], r_rd_x} - {r_px[CW-1], r_px};
    assign cy_new   = {r_rd_y[CW-1], r_rd_y} - {r_py[CW-1], r_py};
    assign bx_rel   = cx_new;
    assign by_rel   = cy_new;
    assign pair_sum = (PW+1)'(r_sqx) + (PW+1)'(r_prod);
    assign scan_upd = (r_cidx == '0) || (pair_sum < r_best);

    // projection helpers
    assign prod_s   = r_psgn ? ((PW+2)'(0) - (PW+2)'(r_prod)) : (PW+2)'(r_prod);
    assign num_f    = r_num + prod_s;
    assign skip_seg = (r_den == '0) || num_f[PW+1] || (num_f > {1'b0, r_den});
    assign d_axis   = r_axis ? r_dy : r_dx;
    assign q_axis   = r_axis ? r_qy : r_qx;
    assign rnd      = ({r_rem, 1'b0} >= {1'b0, r_dden});
    assign ox       = (DW+1)'(r_dlo) + (DW+1)'(rnd);
    assign ox_s     = d_axis[DW-1] ? ((DW+1)'(0) - ox) : ox;
    assign foot     = ox_s - {q_axis[DW-1], q_axis};

    // root step
    assign sq_rb = r_r + r_bit;

    // force shaping
    assign e_val   = r_r[EW-1:0];
    assign e_w     = BW2'(e_val);
    assign band_w  = BW2'(r_band);
    assign band2_w = band_w << 1;
    always_comb begin
        f_is_zero = 1'b0;
        x_val     = '0;
        if (e_w < band_w)
            x_val = BAND_W'(e_w);
        else if (e_w < band2_w)
            x_val = BAND_W'(band2_w - e_w);
        else
            f_is_zero = 1'b1;
    end
    assign f_now   = r_fzero ? '0 : r_dlo[FMAX_W-1:0];
    assign m_clamp = (r_dlo > QW'(FORCE_LIMIT)) ? FORCE_W'(FORCE_LIMIT) : FORCE_W'(r_dlo);

    // multiplier operand select
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (r_state)
            S_SCAN0: begin mul_a = MW'(mag(cx_new)); mul_b = MW'(mag(cx_new)); end
            S_SCAN1: begin mul_a = MW'(mag(r_cy));   mul_b = MW'(mag(r_cy));   end
            S_DEN0:  begin mul_a = MW'(mag(r_dx));   mul_b = MW'(mag(r_dx));   end
            S_DEN1:  begin mul_a = MW'(mag(r_dy));   mul_b = MW'(mag(r_dy));   end
            S_NUM0: begin
                mul_a = MW'(mag(r_qx)); mul_b = MW'(mag(r_dx));
                mul_neg = r_qx[DW-1] ^ r_dx[DW-1];
            end
            S_NUM1: begin
                mul_a = MW'(mag(r_qy)); mul_b = MW'(mag(r_dy));
                mul_neg = r_qy[DW-1] ^ r_dy[DW-1];
            end
            S_OFF0:  begin mul_a = MW'(r_num[DW-1:0]);    mul_b = MW'(mag(d_axis)); end
            S_OFF1:  begin mul_a = MW'(r_num[PW-1:DW]);   mul_b = MW'(mag(d_axis)); end
            S_FD0:   begin mul_a = MW'(mag(r_fx)); mul_b = MW'(mag(r_fx)); end
            S_FD1:   begin mul_a = MW'(mag(r_fy)); mul_b = MW'(mag(r_fy)); end
            S_FRC0:  begin mul_a = MW'(r_fmax); mul_b = MW'(x_val); end
            S_FRC2:  begin mul_a = MW'(f_now);  mul_b = MW'(mag(r_ex)); end
            S_FRC4:  begin mul_a = MW'(r_f);    mul_b = MW'(mag(r_ey)); end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_psgn <= mul_neg;
    end

    // divider operand select
    always_comb begin
        div_load = 1'b0;
        div_n    = '0;
        div_d    = '0;
        case (r_state)
            S_OFF2: begin
                div_load = 1'b1;
                div_n = NW'(r_nacc) + (NW'(r_prod) << DW);
                div_d = RW'(r_den);
            end
            S_FRC1: begin
                div_load = 1'b1;
                div_n = NW'(r_prod);
                div_d = RW'(r_band);
            end
            S_FRC3, S_FRC5: begin
                div_load = 1'b1;
                div_n = (NW'(r_prod) << 1) + NW'(e_val);
                div_d = RW'(e_val) << 1;
            end
            default: ;
        endcase
    end

    // restoring divide step
    assign div_t  = {r_rem[RW-2:0], r_dlo[QW-1]};
    assign div_ge = (div_t >= r_dden);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (div_load) begin
                r_dlo  <= div_n[QW-1:0];
                r_rem  <= RW'(div_n >> QW);
                r_dden <= div_d;
                r_cnt  <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_mode == MODE_QUERY)) begin
                        r_px    <= i_pos_x;
                        r_py    <= i_pos_y;
                        r_n     <= n_len;
                        r_band  <= n_band;
                        r_fmax  <= n_fmax;
                        r_state <= S_SCAN_PRE;
                    end
                end
                S_SCAN_PRE: begin
                    r_idx   <= '0;
                    r_pend  <= 1'b0;
                    r_state <= S_SCAN0;
                end
                // compare the previous vertex, start squares of this one
                S_SCAN0: begin
                    if (r_pend && scan_upd) begin
                        r_best <= pair_sum;
                        r_near <= AW'(r_cidx);
                        r_ex   <= r_cx;
                        r_ey   <= r_cy;
                    end
                    r_cx    <= cx_new;
                    r_cy    <= cy_new;
                    r_cidx  <= r_idx;
                    r_pend  <= 1'b1;
                    r_state <= S_SCAN1;
                end
                S_SCAN1: begin
                    r_sqx <= PW'(r_prod);
                    r_idx <= r_idx + IW'(1);
                    r_state <= ((r_idx + IW'(1)) == r_n) ? S_SCAN_END : S_SCAN0;
                end
                S_SCAN_END: begin
                    if (scan_upd) begin
                        r_best <= pair_sum;
                        r_near <= AW'(r_cidx);
                        r_ex   <= r_cx;
                        r_ey   <= r_cy;
                    end
                    r_qx    <= '0 - (scan_upd ? r_cx : r_ex);
                    r_qy    <= '0 - (scan_upd ? r_cy : r_ey);
                    r_seg   <= 2'd0;
                    r_state <= S_SEG_SEL;
                end
                // previous segment, then next, then root
                S_SEG_SEL: begin
                    if (seg_prev) begin
                        r_seg   <= 2'd1;
                        r_state <= S_GET_B;
                    end else if (seg_next) begin
                        r_seg   <= 2'd2;
                        r_state <= S_GET_B;
                    end else begin
                        r_s     <= SW'(r_best);
                        r_r     <= '0;
                        r_bit   <= SQ_TOP;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_GET_B: begin
                    r_dx    <= bx_rel + r_qx;
                    r_dy    <= by_rel + r_qy;
                    r_state <= S_DEN0;
                end
                S_DEN0: r_state <= S_DEN1;
                S_DEN1: begin
                    r_den   <= (PW+1)'(r_prod);
                    r_state <= S_NUM0;
                end
                S_NUM0: begin
                    r_den   <= r_den + (PW+1)'(r_prod);
                    r_state <= S_NUM1;
                end
                S_NUM1: begin
                    r_num   <= prod_s;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (skip_seg) begin
                        r_state <= S_SEG_SEL;
                    end else begin
                        r_num   <= num_f;
                        r_axis  <= 1'b0;
                        r_state <= S_OFF0;
                    end
                end
                S_OFF0: r_state <= S_OFF1;
                S_OFF1: begin
                    r_nacc  <= PW'(r_prod);
                    r_state <= S_OFF2;
                end
                S_OFF2: begin
                    r_ret   <= S_OFF3;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= div_ge ? (div_t - r_dden) : div_t;
                    r_dlo <= {r_dlo[QW-2:0], div_ge};
                    r_cnt <= r_cnt + CNTW'(1);
                    if (r_cnt == CNTW'(QW - 1))
                        r_state <= r_ret;
                end
                // foot coordinate relative to the tool
                S_OFF3: begin
                    if (!r_axis) begin
                        r_fx    <= DW'(foot);
                        r_axis  <= 1'b1;
                        r_state <= S_OFF0;
                    end else begin
                        r_fy    <= DW'(foot);
                        r_state <= S_FD0;
                    end
                end
                S_FD0: r_state <= S_FD1;
                S_FD1: begin
                    r_sqx   <= PW'(r_prod);
                    r_state <= S_FD2;
                end
                S_FD2: begin
                    if (pair_sum < r_best) begin
                        r_best <= pair_sum;
                        r_ex   <= r_fx;
                        r_ey   <= r_fy;
                    end
                    r_state <= S_SEG_SEL;
                end
                // two operand bits per pass, one root bit per cycle
                S_SQRT: begin
                    if (r_s >= sq_rb) begin
                        r_s <= r_s - sq_rb;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + CNTW'(1);
                    if (r_cnt == CNTW'(SW / 2 - 1))
                        r_state <= S_FRC0;
                end
                S_FRC0: begin
                    r_fzero <= f_is_zero;
                    r_state <= f_is_zero ? S_FRC2 : S_FRC1;
                end
                S_FRC1: begin
                    r_ret   <= S_FRC2;
                    r_state <= S_DIV;
                end
                S_FRC2: begin
                    r_f <= f_now;
                    if (e_val == '0) begin
                        r_out_fx   <= '0;
                        r_out_fy   <= '0;
                        r_out_ex   <= r_ex;
                        r_out_ey   <= r_ey;
                        r_out_near <= IDX_W'(r_near);
                        r_valid    <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_FRC3;
                    end
                end
                S_FRC3: begin
                    r_ret   <= S_FRC4;
                    r_state <= S_DIV;
                end
                S_FRC4: begin
                    r_fox   <= r_ex[DW-1] ? (FORCE_W'(0) - m_clamp) : m_clamp;
                    r_state <= S_FRC5;
                end
                S_FRC5: begin
                    r_ret   <= S_FRC6;
                    r_state <= S_DIV;
                end
                S_FRC6: begin
                    r_out_fx   <= r_fox;
                    r_out_fy   <= r_ey[DW-1] ? m_clamp : (FORCE_W'(0) - m_clamp);
                    r_out_ex   <= r_ex;
                    r_out_ey   <= r_ey;
                    r_out_near <= IDX_W'(r_near);
                    r_valid    <= 1'b1;
                    r_state    <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/pvff_checker.sv =====
// Port-level checks for the polyline virtual fixture force unit, bound to the top level.
// Depends on pvff_pkg and polyline_virtual_fixture_force_unit.
`timescale 1ns / 1ps

module pvff_checker
    import pvff_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_start,
    input logic                         o_busy,
    input logic                         i_mode,
    input logic                         o_valid,
    input logic signed [FORCE_W-1:0]    o_force_x,
    input logic signed [FORCE_W-1:0]    o_force_y,
    input logic signed [COORD_BITS:0]   o_error_x,
    input logic signed [COORD_BITS:0]   o_error_y
);

    // a result ends the query
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result strobed while still busy");

    // a query word starts the sequencer
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_mode == MODE_QUERY) |=> o_busy)
        else $error("query accepted without going busy");

    // a load word gives no result and no busy time
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_mode == MODE_LOAD) |=> (!o_busy && !o_valid))
        else $error("load word caused busy or a result");

    // zero error means zero force
    a_zero_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_x == '0 && o_error_y == '0) |->
            (o_force_x == '0 && o_force_y == '0))
        else $error("nonzero force at zero error");

endmodule

bind polyline_virtual_fixture_force_unit pvff_checker #(.COORD_BITS(COORD_BITS)) u_pvff_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (i_start),
    .o_busy    (o_busy),
    .i_mode    (i_mode),
    .o_valid   (o_valid),
    .o_force_x (o_force_x),
    .o_force_y (o_force_y),
    .o_error_x (o_error_x),
    .o_error_y (o_error_y)
);

// ===== tb/tb_polyline_virtual_fixture_force_unit.sv =====
// Self-checking testbench for polyline_virtual_fixture_force_unit: loads path
// vertices, runs queries and compares every strobed result with a predictor.
// Depends on pvff_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_polyline_virtual_fixture_force_unit;
    import pvff_pkg::*;

    localparam int DEPTH     = DEF_PATH_DEPTH;
    localparam int CB        = DEF_COORD_BITS;
    localparam int CYC_LIMIT = 20000000;
    localparam longint CMAX  = (64'sd1 <<< (CB - 1)) - 1;
    localparam longint CMIN  = -(64'sd1 <<< (CB - 1));

    typedef struct {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic signed [CB:0]        error_x;
        logic signed [CB:0]        error_y;
        logic [IDX_W-1:0]          nearest;
    } t_fixture_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic                 o_busy;
    logic                 i_mode = MODE_LOAD;
    logic [IDX_W-1:0]     i_vertex_index = '0;
    logic signed [CB-1:0] i_pos_x = '0;
    logic signed [CB-1:0] i_pos_y = '0;
    logic                 o_valid;
    logic signed [FORCE_W-1:0] o_force_x, o_force_y;
    logic signed [CB:0]   o_error_x, o_error_y;
    logic [IDX_W-1:0]     o_nearest_index;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IW-1:0]    i_cfg_index = CFG_PATH_LENGTH;
    logic [CFG_DW-1:0]    i_cfg_data = '0;

    // predictor state
    longint          vert_x [DEPTH];
    longint          vert_y [DEPTH];
    bit              loaded [DEPTH];
    longint unsigned len_reg, band_reg, fmax_reg;
    t_fixture_result pending_q[$];

    int  err_count = 0;
    int  query_count = 0, load_count = 0, checked_count = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;

    polyline_virtual_fixture_force_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(i_start), .o_busy(o_busy), .i_mode(i_mode),
        .i_vertex_index(i_vertex_index), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .o_valid(o_valid), .o_force_x(o_force_x), .o_force_y(o_force_y),
        .o_error_x(o_error_x), .o_error_y(o_error_y),
        .o_nearest_index(o_nearest_index),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned sq(longint v);
        longint unsigned a;
        a = mag(v);
        return a * a;
    endfunction

    // a*b/den rounded, halves up
    function automatic longint unsigned scale_round(longint unsigned a, longint unsigned b,
                                                   longint unsigned den);
        bit [127:0] p, q, r;
        p = a;
        p = p * b;
        q = p / den;
        r = p % den;
        if (2 * r >= den) q = q + 1;
        return q[63:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // foot of the tool on segment a->b, kept if strictly closer
    function automatic void try_foot(input longint ax, ay, bx, by, px, py,
                                     inout longint ex, ey,
                                     inout longint unsigned best);
        longint dx, dy, num, fx, fy;
        longint unsigned den, ox, oy, d;
        dx = bx - ax;
        dy = by - ay;
        num = (px - ax) * dx + (py - ay) * dy;
        den = sq(dx) + sq(dy);
        if (den == 0 || num < 0 || longint'(num) > longint'(den)) return;
        ox = scale_round(num, mag(dx), den);
        oy = scale_round(num, mag(dy), den);
        fx = ax + (dx < 0 ? -longint'(ox) : longint'(ox)) - px;
        fy = ay + (dy < 0 ? -longint'(oy) : longint'(oy)) - py;
        d = sq(fx) + sq(fy);
        if (d < best) begin
            best = d;
            ex = fx;
            ey = fy;
        end
    endfunction

    function automatic longint force_share(longint unsigned f, longint c, longint unsigned e);
        longint unsigned m;
        m = (f * mag(c) * 2 + e) / (2 * e);
        if (m > FORCE_LIMIT) m = FORCE_LIMIT;
        return c < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic t_fixture_result predict_fixture(longint px, longint py);
        t_fixture_result res;
        longint unsigned n, band, fmax, best, d, e, f;
        longint ex, ey, cx, cy, fxo, fyo;
        int near;
        n = len_reg < 2 ? 2 : len_reg;
        if (n > DEPTH) n = DEPTH;
        band = band_reg < 1 ? 1 : band_reg;
        if (band > BAND_LIMIT) band = BAND_LIMIT;
        fmax = fmax_reg > FORCE_LIMIT ? FORCE_LIMIT : fmax_reg;
        near = 0;
        ex = vert_x[0] - px;
        ey = vert_y[0] - py;
        best = sq(ex) + sq(ey);
        for (int i = 1; i < n; i++) begin
            cx = vert_x[i] - px;
            cy = vert_y[i] - py;
            d = sq(cx) + sq(cy);
            if (d < best) begin
                best = d;
                near = i;
                ex = cx;
                ey = cy;
            end
        end
        if (near > 0)
            try_foot(vert_x[near], vert_y[near], vert_x[near-1], vert_y[near-1],
                     px, py, ex, ey, best);
        if (near + 1 < n)
            try_foot(vert_x[near], vert_y[near], vert_x[near+1], vert_y[near+1],
                     px, py, ex, ey, best);
        e = int_sqrt(sq(ex) + sq(ey));
        f = 0;
        if (e < band) f = fmax * e / band;
        else if (e < 2 * band) f = fmax * (2 * band - e) / band;
        fxo = 0;
        fyo = 0;
        if (e != 0) begin
            fxo = force_share(f, ex, e);
            fyo = -force_share(f, ey, e);
        end
        res.force_x = fxo[FORCE_W-1:0];
        res.force_y = fyo[FORCE_W-1:0];
        res.error_x = ex[CB:0];
        res.error_y = ey[CB:0];
        res.nearest = near[IDX_W-1:0];
        return res;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_fixture_result want;
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                $error("result word with no query waiting");
                err_count++;
            end else begin
                want = pending_q.pop_front();
                checked_count++;
                if (o_force_x !== want.force_x) begin
                    $error("force_x exp %0d got %0d", want.force_x, o_force_x);
                    err_count++;
                end
                if (o_force_y !== want.force_y) begin
                    $error("force_y exp %0d got %0d", want.force_y, o_force_y);
                    err_count++;
                end
                if (o_error_x !== want.error_x) begin
                    $error("error_x exp %0d got %0d", want.error_x, o_error_x);
                    err_count++;
                end
                if (o_error_y !== want.error_y) begin
                    $error("error_y exp %0d got %0d", want.error_y, o_error_y);
                    err_count++;
                end
                if (o_nearest_index !== want.nearest) begin
                    $error("nearest_index exp %0d got %0d", want.nearest, o_nearest_index);
                    err_count++;
                end
            end
        end
    end

    // ---------------- drivers ----------------
    task automatic idle_gap(int n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // send one word; start stays high for a following word
    task automatic send_word(logic mode, int slot, longint px, longint py);
        if (!calm && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 10));
        i_start        <= 1'b1;
        i_mode         <= mode;
        i_vertex_index <= slot[IDX_W-1:0];
        i_pos_x        <= px[CB-1:0];
        i_pos_y        <= py[CB-1:0];
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (mode == MODE_LOAD) begin
            vert_x[slot] = px;
            vert_y[slot] = py;
            loaded[slot] = 1'b1;
            load_count++;
        end else begin
            pending_q.insert(pending_q.size(), predict_fixture(px, py));
            query_count++;
        end
    endtask

    task automatic load_vertex(int slot, longint px, longint py);
        send_word(MODE_LOAD, slot, px, py);
    endtask

    function automatic int active_len();
        return len_reg < 2 ? 2 : (len_reg > DEPTH ? DEPTH : int'(len_reg));
    endfunction

    // queries only ever read slots that were loaded
    task automatic query_tool(longint px, longint py);
        for (int i = 0; i < active_len(); i++)
            if (!loaded[i]) load_vertex(i, rand_coord(), rand_coord());
        send_word(MODE_QUERY, 0, px, py);
    endtask

    // wait until every query answered, then let the unit settle
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0 || o_busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, int unsigned data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_DW-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PATH_LENGTH: len_reg  = data & 32'h7FF;
            CFG_BAND_WIDTH:  band_reg = data & 32'hFFFFF;
            CFG_FORCE_MAX:   fmax_reg = data & 32'h7FFFF;
            default: ;
        endcase
    endtask

    function automatic longint rand_coord();
        logic signed [CB-1:0] v;
        v = CB'($urandom());
        return v;
    endfunction

    function automatic longint clip(longint v);
        return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
    endfunction

    function automatic longint jitter(longint span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    // ---------------- tests ----------------
    task automatic test_reset_defaults();
        // extremes of coordinates with the reset register values
        load_vertex(0, CMAX, CMAX);
        load_vertex(1, CMIN, CMIN);
        query_tool(CMAX, CMAX);        // zero error
        query_tool(CMIN, CMAX);        // huge error, foot on diagonal
        query_tool(CMAX, CMIN);
        query_tool(0, 0);
        query_tool(CMAX - 15000, CMAX); // inside the band
        query_tool(CMAX - 30000, CMAX); // falling side
    endtask

    task automatic test_segments();
        write_reg(CFG_PATH_LENGTH, 4);
        write_reg(CFG_BAND_WIDTH, 1000);
        write_reg(CFG_FORCE_MAX, 300000);
        load_vertex(0, 0, 0);
        load_vertex(1, 4000, 0);
        load_vertex(2, 4000, 0);       // degenerate segment
        load_vertex(3, 4000, 3000);
        query_tool(1500, 700);         // foot past slot 0 end
        query_tool(-500, 200);         // beyond the first vertex
        query_tool(4600, 2900);        // last slot, previous only
        query_tool(4300, 1600);        // next segment of duplicated vertex
        query_tool(2000, 0);           // on the path, zero error
        query_tool(2000, -1500);       // falling slope of the band
        query_tool(2000, 2500);        // beyond twice the band
        load_vertex(1, 0, 0);          // tie: first slot wins
        query_tool(-300, -400);
    endtask

    task automatic test_registers();
        // out-of-range values saturate
        write_reg(CFG_PATH_LENGTH, 0);
        write_reg(CFG_BAND_WIDTH, 0);
        write_reg(CFG_FORCE_MAX, 0);
        query_tool(10, 3);
        write_reg(CFG_PATH_LENGTH, 1);
        write_reg(CFG_FORCE_MAX, 524287);
        query_tool(1, 0);
        query_tool(-2, 1);
        write_reg(CFG_BAND_WIDTH, 1048575);
        query_tool(700000, -123456);
        // whole table, every slot index
        for (int i = 0; i < DEPTH; i++) load_vertex(i, rand_coord(), rand_coord());
        write_reg(CFG_PATH_LENGTH, 2047);
        query_tool(rand_coord(), rand_coord());
        query_tool(vert_x[DEPTH-1] + 5, vert_y[DEPTH-1]);
        write_reg(CFG_PATH_LENGTH, 1024);
        query_tool(vert_x[0], vert_y[0] - 9);
    endtask

    task automatic test_random(int total);
        int sent, n, k, nq;
        longint band, bx, by, step;
        sent = 0;
        while (sent < total) begin
            calm = (sent > total * 4 / 5);
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 1024)
                                             : $urandom_range(2, 12);
            case ($urandom_range(0, 3))
                0: band = $urandom_range(1, 50);
                1: band = $urandom_range(1, 1000000);
                2: band = 1000000;
                default: band = $urandom_range(1000, 40000);
            endcase
            write_reg(CFG_PATH_LENGTH, n);
            write_reg(CFG_BAND_WIDTH, band);
            write_reg(CFG_FORCE_MAX, $urandom_range(0, 3) == 0 ? 500000
                                     : $urandom_range(0, 524287));
            // well-formed polyline with random content
            bx = rand_coord();
            by = rand_coord();
            step = $urandom_range(1, 4) * band + $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) != 0 || i == 0)
                    load_vertex(i, clip(bx + jitter(step)), clip(by + jitter(step)));
                else
                    load_vertex(i, vert_x[i-1], vert_y[i-1]);
                bx = vert_x[i];
                by = vert_y[i];
                sent++;
            end
            nq = $urandom_range(4, 12);
            for (int j = 0; j < nq; j++) begin
                k = $urandom_range(0, n - 1);
                case ($urandom_range(0, 5))
                    0: query_tool(rand_coord(), rand_coord());
                    1: load_vertex($urandom_range(0, n - 1), rand_coord(), rand_coord());
                    2: query_tool(vert_x[k], vert_y[k]);
                    3: query_tool(clip((vert_x[k] + vert_x[(k+1)%n]) / 2 + jitter(2 * band)),
                                  clip((vert_y[k] + vert_y[(k+1)%n]) / 2 + jitter(2 * band)));
                    default: query_tool(clip(vert_x[k] + jitter(3 * band)),
                                        clip(vert_y[k] + jitter(3 * band)));
                endcase
                sent++;
            end
        end
    endtask

    initial begin
        len_reg  = LEN_RESET;
        band_reg = BAND_RESET;
        fmax_reg = FMAX_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_segments();
        test_registers();
        test_random(500);

        drain();
        repeat (50) @(posedge i_clk);
        $display("covered %0d loads and %0d queries, %0d results checked,",
                 load_count, query_count, checked_count);
        $display("over saturated, extreme and random register settings");
        if (err_count == 0 && pending_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
